// ===== rtl/core/afpd_pkg.sv =====
// Package with constants, register addresses and helper functions for the attitude filter.
package afpd_pkg;

  localparam int CordicSteps = 16;
  localparam int CordicEff = (CordicSteps > 24) ? 24 : CordicSteps;

  localparam logic [4:0] AddrAlpha  = 5'd0;
  localparam logic [4:0] AddrPeriod = 5'd4;
  localparam logic [4:0] AddrRate   = 5'd8;
  localparam logic [4:0] AddrKp     = 5'd12;
  localparam logic [4:0] AddrKd     = 5'd16;
  localparam logic [4:0] AddrTroll  = 5'd20;
  localparam logic [4:0] AddrTpitch = 5'd24;
  localparam logic [4:0] AddrCap    = 5'd28;

  localparam logic signed [31:0] Deg180 = 32'sd11796480;

  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0: atan_deg = 32'sd2949120;
      5'd1: atan_deg = 32'sd1740967;
      5'd2: atan_deg = 32'sd919879;
      5'd3: atan_deg = 32'sd466945;
      5'd4: atan_deg = 32'sd234379;
      5'd5: atan_deg = 32'sd117304;
      5'd6: atan_deg = 32'sd58666;
      5'd7: atan_deg = 32'sd29335;
      5'd8: atan_deg = 32'sd14668;
      5'd9: atan_deg = 32'sd7334;
      5'd10: atan_deg = 32'sd3667;
      5'd11: atan_deg = 32'sd1833;
      5'd12: atan_deg = 32'sd917;
      5'd13: atan_deg = 32'sd458;
      5'd14: atan_deg = 32'sd229;
      5'd15: atan_deg = 32'sd115;
      5'd16: atan_deg = 32'sd57;
      5'd17: atan_deg = 32'sd29;
      5'd18: atan_deg = 32'sd14;
      5'd19: atan_deg = 32'sd7;
      5'd20: atan_deg = 32'sd4;
      5'd21: atan_deg = 32'sd2;
      5'd22: atan_deg = 32'sd1;
      default: atan_deg = 32'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (x < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = x[31:0];
  endfunction

endpackage

// ===== rtl/core/attitude_filter_pd_motor_mixer_top.sv =====
// Attitude filter, PD controller and motor mixer with a shared sequenced datapath.
// The pitch CORDIC run is skipped when the pitch vector is zero, and the mix waits while the
// previous result is still held by the output stall. The input stalls while an item is in
// work, so a new item is taken only once the last one is through the sequence.
// Work is two CORDIC runs of 16 steps on one CORDIC unit and a 24-step square root.
// Reset clears angles, previous errors and the sequencer, and loads register defaults.
module attitude_filter_pd_motor_mixer_top (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [15:0] motor_1,
  output logic signed [15:0] motor_2,
  output logic signed [15:0] motor_3,
  output logic signed [15:0] motor_4,
  output logic signed [31:0] roll_out,
  output logic signed [31:0] pitch_out,
  output logic signed [31:0] yaw_out,
  output logic signed [31:0] roll_rate_out,
  output logic signed [31:0] pitch_rate_out,
  output logic signed [31:0] yaw_rate_out
);
  import afpd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROLLI = 4'd1;
  localparam logic [3:0] S_ROLL  = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_PITI  = 4'd4;
  localparam logic [3:0] S_PIT   = 4'd5;
  localparam logic [3:0] S_GYRO  = 4'd6;
  localparam logic [3:0] S_BLEND = 4'd7;
  localparam logic [3:0] S_RATE  = 4'd8;
  localparam logic [3:0] S_PD    = 4'd9;
  localparam logic [3:0] S_MIX   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [16:0] blend_alpha;
  logic [23:0] sample_period;
  logic [15:0] sample_rate, gain_prop, gain_deriv;
  logic signed [24:0] target_roll, target_pitch;
  logic [14:0] motor_cap;

  logic signed [31:0] roll_angle, pitch_angle, yaw_angle;
  logic signed [31:0] prev_roll_error, prev_pitch_error;

  logic [3:0] state;
  logic [4:0] cnt;
  logic [1:0] sub;
  logic signed [15:0] gx, gy, gz, ax, ay, az;

  logic signed [26:0] cx, cy;
  logic signed [31:0] cz, acc_roll, acc_pitch;
  logic [47:0] sq_v, sq_r, sq_bit;
  logic signed [31:0] st_r, st_p, st_y, nr, np, ny, er, ep;
  logic signed [31:0] rate_r, rate_p, rate_y;
  logic signed [63:0] acc, rsum;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr)
      AddrAlpha:  prdata = {15'd0, blend_alpha};
      AddrPeriod: prdata = {8'd0, sample_period};
      AddrRate:   prdata = {16'd0, sample_rate};
      AddrKp:     prdata = {16'd0, gain_prop};
      AddrKd:     prdata = {16'd0, gain_deriv};
      AddrTroll:  prdata = {{7{target_roll[24]}}, target_roll};
      AddrTpitch: prdata = {{7{target_pitch[24]}}, target_pitch};
      AddrCap:    prdata = {17'd0, motor_cap};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_alpha <= 17'd64880; sample_period <= 24'd167772; sample_rate <= 16'd100;
      gain_prop <= 16'd256; gain_deriv <= 16'd0;
      target_roll <= '0; target_pitch <= '0; motor_cap <= 15'd12800;
    end else if (cfg_wr) begin
      case (paddr)
        AddrAlpha:  blend_alpha <= pwdata[16:0];
        AddrPeriod: sample_period <= pwdata[23:0];
        AddrRate:   sample_rate <= pwdata[15:0];
        AddrKp:     gain_prop <= pwdata[15:0];
        AddrKd:     gain_deriv <= pwdata[15:0];
        AddrTroll:  target_roll <= pwdata[24:0];
        AddrTpitch: target_pitch <= pwdata[24:0];
        AddrCap:    motor_cap <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  // Shared units: one CORDIC step, one square-root step, one multiplier.
  logic signed [26:0] xs, ys;
  logic signed [31:0] ang, cz_next;
  assign xs = cx >>> cnt;
  assign ys = cy >>> cnt;
  assign ang = atan_deg(cnt);
  assign cz_next = (cy > 0) ? cz + ang : (cy < 0) ? cz - ang : cz;

  logic signed [32:0] sq_sum;
  assign sq_sum = 33'(ay) * 33'(ay) + 33'(az) * 33'(az);

  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [16:0] alpha;
  assign alpha = (blend_alpha > 17'd65536) ? 17'd65536 : blend_alpha;

  logic signed [31:0] cur_old, cur_acc;
  logic signed [15:0] cur_g;
  always_comb begin
    case (sub)
      2'd0: begin cur_old = roll_angle; cur_acc = acc_roll; cur_g = gx; end
      2'd1: begin cur_old = pitch_angle; cur_acc = acc_pitch; cur_g = gy; end
      default: begin cur_old = yaw_angle; cur_acc = '0; cur_g = gz; end
    endcase
  end
  logic signed [31:0] cur_step, cur_new;
  assign cur_step = (sub == 2'd0) ? st_r : (sub == 2'd1) ? st_p : st_y;
  assign cur_new = (sub == 2'd0) ? nr : (sub == 2'd1) ? np : ny;

  always_comb begin
    mul_a = '0; mul_b = '0;
    case (state)
      S_GYRO: begin mul_a = 34'(cur_g); mul_b = {1'b0, sample_period}; end
      S_BLEND: begin
        if (cnt[0] == 1'b0) begin
          mul_a = 34'(cur_old) + 34'(cur_step); mul_b = 25'(alpha);
        end else begin
          mul_a = 34'(cur_acc); mul_b = 25'(18'd65536 - 18'(alpha));
        end
      end
      S_RATE: begin mul_a = 34'(cur_new) - 34'(cur_old); mul_b = 25'(sample_rate); end
      S_PD: begin
        case (cnt[1:0])
          2'd0: begin mul_a = 34'(er); mul_b = 25'(gain_prop); end
          2'd1: begin mul_a = 34'(er) - 34'(prev_roll_error); mul_b = 25'(gain_deriv); end
          2'd2: begin mul_a = 34'(ep); mul_b = 25'(gain_prop); end
          default: begin mul_a = 34'(ep) - 34'(prev_pitch_error); mul_b = 25'(gain_deriv); end
        endcase
      end
      default: ;
    endcase
  end

  function automatic logic signed [15:0] mot(input logic signed [63:0] m,
                                            input logic [14:0] cap);
    logic signed [63:0] r;
    logic signed [63:0] c;
    r = (m + 64'sd65536) >>> 17;
    c = 64'(cap);
    if (r > c) mot = 16'(c);
    else if (r < -c) mot = 16'(-c);
    else mot = r[15:0];
  endfunction

  logic signed [63:0] blend_r;
  assign blend_r = (acc + 64'(mul_p) + 64'sd32768) >>> 16;
  logic signed [63:0] step_r;
  assign step_r = (64'(mul_p) + 64'sd2048) >>> 12;
  logic [47:0] sq_t;
  assign sq_t = sq_r + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; cnt <= '0; sub <= '0;
      roll_angle <= '0; pitch_angle <= '0; yaw_angle <= '0;
      prev_roll_error <= '0; prev_pitch_error <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_MIX) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          gx <= gyro_x; gy <= gyro_y; gz <= gyro_z;
          ax <= accel_x; ay <= accel_y; az <= accel_z;
          state <= S_ROLLI;
        end
        S_ROLLI: begin
          cnt <= '0;
          cz <= (az < 0) ? ((ay >= 0) ? Deg180 : -Deg180) : 32'sd0;
          if (az < 0) begin
            cx <= -(27'(az) <<< 8); cy <= -(27'(ay) <<< 8);
          end else begin
            cx <= 27'(az) <<< 8; cy <= 27'(ay) <<< 8;
          end
          sq_v <= 48'(sq_sum) << 16;
          state <= S_ROLL;
        end
        S_ROLL, S_PIT: begin
          if (cy > 0) begin cx <= cx + ys; cy <= cy - xs; end
          else if (cy < 0) begin cx <= cx - ys; cy <= cy + xs; end
          cz <= cz_next;
          if (cnt == 5'(CordicEff - 1)) begin
            cnt <= '0;
            if (state == S_ROLL) begin
              acc_roll <= (ay == 0 && az == 0) ? 32'sd0 : cz_next;
              sq_r <= '0; sq_bit <= 48'h1 << 46; state <= S_SQRT;
            end else begin
              acc_pitch <= cz_next; state <= S_GYRO; sub <= '0;
            end
          end else cnt <= cnt + 5'd1;
        end
        S_SQRT: begin
          // Bit-serial integer square root of (ay^2+az^2) shifted up by 16.
          if (sq_bit != 0) begin
            if (sq_v >= sq_t) begin
              sq_v <= sq_v - sq_t; sq_r <= (sq_r >> 1) + sq_bit;
            end else sq_r <= sq_r >> 1;
            sq_bit <= sq_bit >> 2;
          end else state <= S_PITI;
        end
        S_PITI: begin
          cz <= '0;
          cx <= 27'(sq_r);
          cy <= -(27'(ax) <<< 8);
          if (sq_r == 0 && ax == 0) begin acc_pitch <= '0; state <= S_GYRO; sub <= '0; end
          else state <= S_PIT;
        end
        S_GYRO: begin
          case (sub)
            2'd0: st_r <= step_r[31:0];
            2'd1: st_p <= step_r[31:0];
            default: st_y <= step_r[31:0];
          endcase
          if (sub == 2'd2) begin sub <= '0; cnt <= '0; state <= S_BLEND; end
          else sub <= sub + 2'd1;
        end
        S_BLEND: begin
          if (sub == 2'd2) begin
            ny <= sat32(64'(yaw_angle) + 64'(st_y));
            sub <= '0; cnt <= '0; state <= S_RATE;
          end else if (cnt[0] == 1'b0) begin
            acc <= 64'(mul_p); cnt <= cnt + 5'd1;
          end else begin
            if (sub == 2'd0) nr <= sat32(blend_r); else np <= sat32(blend_r);
            sub <= sub + 2'd1; cnt <= '0;
          end
        end
        S_RATE: begin
          case (sub)
            2'd0: rate_r <= sat32(64'(mul_p));
            2'd1: rate_p <= sat32(64'(mul_p));
            default: rate_y <= sat32(64'(mul_p));
          endcase
          if (sub == 2'd2) begin
            sub <= '0; cnt <= '0; state <= S_PD;
            er <= sat32(64'(target_roll) - 64'(nr));
            ep <= sat32(64'(target_pitch) - 64'(np));
          end else sub <= sub + 2'd1;
        end
        S_PD: begin
          case (cnt[1:0])
            2'd0: acc <= 64'(mul_p);
            2'd1: rsum <= acc + 64'(mul_p);
            2'd2: acc <= 64'(mul_p);
            default: acc <= acc + 64'(mul_p);
          endcase
          if (cnt[1:0] == 2'd3) state <= S_MIX; else cnt <= cnt + 5'd1;
        end
        S_MIX: begin
          if (!out_valid || !out_stall) begin
            motor_1 <= mot(rsum - acc, motor_cap);
            motor_2 <= mot(rsum + acc, motor_cap);
            motor_3 <= mot(-rsum - acc, motor_cap);
            motor_4 <= mot(-rsum + acc, motor_cap);
            roll_out <= nr; pitch_out <= np; yaw_out <= ny;
            roll_rate_out <= rate_r; pitch_rate_out <= rate_p; yaw_rate_out <= rate_y;
            roll_angle <= nr; pitch_angle <= np; yaw_angle <= ny;
            prev_roll_error <= er; prev_pitch_error <= ep;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_mix_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> out_valid) else $error("result missing after mix");
endmodule

// ===== tb/tb_attitude_filter_pd_motor_mixer_top.sv =====
// Self-checking testbench for the attitude filter, PD controller and motor mixer.
module tb_attitude_filter_pd_motor_mixer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import afpd_pkg::*;

  typedef struct packed {
    logic signed [15:0] m1, m2, m3, m4;
    logic signed [31:0] roll, pitch, yaw, roll_rate, pitch_rate, yaw_rate;
  } motor_result_t;

  typedef struct packed {
    logic signed [15:0] gx, gy, gz, ax, ay, az;
  } imu_sample_t;

  logic clk = 1'b0, rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [15:0] motor_1, motor_2, motor_3, motor_4;
  logic signed [31:0] roll_out, pitch_out, yaw_out;
  logic signed [31:0] roll_rate_out, pitch_rate_out, yaw_rate_out;

  attitude_filter_pd_motor_mixer_top uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copy of registers and filter state.
  longint alpha_q, period_q, rate_q, kp_q, kd_q, troll_q, tpitch_q, cap_q;
  longint roll_st, pitch_st, yaw_st, prev_er, prev_ep;
  motor_result_t expected_q[$];
  int errors = 0, accepted_in = 0, accepted_out = 0, idle_cycles = 0;
  bit long_hold = 1'b0, rand_idle = 1'b1;

  function automatic longint shr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint round_sh(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint root_u(longint v);
    longint r = 0, b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint tilt_angle(longint y, longint x);
    longint base = 0, z = 0, xs, ys;
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? 11796480 : -11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicEff; i++) begin
      xs = shr(x, i);
      ys = shr(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + tbl[i];
      end else if (y < 0) begin
        x = x - ys; y = y + xs; z = z - tbl[i];
      end
    end
    return base + z;
  endfunction

  function automatic longint cap_clip(longint v);
    if (v > cap_q) return cap_q;
    if (v < -cap_q) return -cap_q;
    return v;
  endfunction

  function automatic motor_result_t predict_attitude(imu_sample_t s);
    motor_result_t r;
    longint a, acc_r, acc_p, mag, sr, sp, sy, nr, np, ny, er, ep, rs, ps;
    a = (alpha_q > 65536) ? 65536 : alpha_q;
    acc_r = tilt_angle(longint'(s.ay) * 256, longint'(s.az) * 256);
    mag = root_u((longint'(s.ay) * s.ay + longint'(s.az) * s.az) << 16);
    acc_p = tilt_angle(-longint'(s.ax) * 256, mag);
    sr = round_sh(longint'(s.gx) * period_q, 12);
    sp = round_sh(longint'(s.gy) * period_q, 12);
    sy = round_sh(longint'(s.gz) * period_q, 12);
    nr = clip32(round_sh(a * (roll_st + sr) + (65536 - a) * acc_r, 16));
    np = clip32(round_sh(a * (pitch_st + sp) + (65536 - a) * acc_p, 16));
    ny = clip32(yaw_st + sy);
    r.roll_rate = 32'(clip32((nr - roll_st) * rate_q));
    r.pitch_rate = 32'(clip32((np - pitch_st) * rate_q));
    r.yaw_rate = 32'(clip32((ny - yaw_st) * rate_q));
    roll_st = nr; pitch_st = np; yaw_st = ny;
    er = clip32(troll_q - nr);
    ep = clip32(tpitch_q - np);
    rs = kp_q * er + kd_q * (er - prev_er);
    ps = kp_q * ep + kd_q * (ep - prev_ep);
    prev_er = er; prev_ep = ep;
    r.m1 = 16'(cap_clip(round_sh(rs - ps, 17)));
    r.m2 = 16'(cap_clip(round_sh(rs + ps, 17)));
    r.m3 = 16'(cap_clip(round_sh(-rs - ps, 17)));
    r.m4 = 16'(cap_clip(round_sh(-rs + ps, 17)));
    r.roll = 32'(nr); r.pitch = 32'(np); r.yaw = 32'(ny);
    return r;
  endfunction

  task automatic write_reg(logic [4:0] addr, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      AddrAlpha: alpha_q = val & 32'h1ffff;
      AddrPeriod: period_q = val & 32'hffffff;
      AddrRate: rate_q = val & 32'hffff;
      AddrKp: kp_q = val & 32'hffff;
      AddrKd: kd_q = val & 32'hffff;
      AddrTroll: troll_q = longint'(signed'(val[24:0]));
      AddrTpitch: tpitch_q = longint'(signed'(val[24:0]));
      AddrCap: cap_q = val & 32'h7fff;
      default: ;
    endcase
  endtask

  task automatic send_sample(imu_sample_t s, bit may_idle = 1'b1);
    int gap;
    gap = (may_idle && rand_idle) ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    gyro_x <= s.gx; gyro_y <= s.gy; gyro_z <= s.gz;
    accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_attitude(s));
    accepted_in++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    s = {$urandom, $urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      s.gx = $signed(s.gx) >>> 6; s.gy = $signed(s.gy) >>> 6; s.gz = $signed(s.gz) >>> 6;
    end
    if ($urandom_range(0, 9) == 0) s.ax = 0;
    if ($urandom_range(0, 9) == 0) begin
      s.ay = 0; s.az = 0;
    end
    return s;
  endfunction

  // Output side: random stalls plus a long hold when requested.
  initial begin
    int wait_n;
    forever begin
      @(posedge clk);
      if (long_hold) out_stall <= 1'b1;
      else if (rand_idle && $urandom_range(0, 3) == 0) begin
        wait_n = $urandom_range(0, 17);
        if (wait_n > 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
        end
        out_stall <= 1'b0;
      end else out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    motor_result_t e, g;
    if (!rst && out_valid && !out_stall) begin
      g = '{motor_1, motor_2, motor_3, motor_4, roll_out, pitch_out, yaw_out,
            roll_rate_out, pitch_rate_out, yaw_rate_out};
      accepted_out++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item %h", $time, g);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e != g) begin
          errors++;
          $display("%0t: mismatch m %0d %0d %0d %0d / %0d %0d %0d %0d", $time,
                   e.m1, e.m2, e.m3, e.m4, g.m1, g.m2, g.m3, g.m4);
          $display("  angles exp %0d %0d %0d act %0d %0d %0d", e.roll, e.pitch, e.yaw,
                   g.roll, g.pitch, g.yaw);
          $display("  rates exp %0d %0d %0d act %0d %0d %0d", e.roll_rate,
                   e.pitch_rate, e.yaw_rate, g.roll_rate, g.pitch_rate, g.yaw_rate);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed();
    imu_sample_t pats[16] = '{
      '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 1000}, '{0, 0, 0, 0, 0, -1000},
      '{0, 0, 0, 0, 1000, 0}, '{0, 0, 0, 0, -1000, 0}, '{0, 0, 0, 500, 0, 0},
      '{32767, 32767, 32767, 32767, 32767, 32767},
      '{-32768, -32768, -32768, -32768, -32768, -32768},
      '{32767, -32768, 32767, -32768, 32767, -32768},
      '{-32768, 32767, -32768, 32767, -32768, 32767},
      '{100, -100, 50, 0, 0, 16384}, '{0, 0, 0, -16384, 0, 16384},
      '{1, -1, 1, -1, 1, -1}, '{-1, 1, -1, 1, -1, 1},
      '{16, 32, -48, 300, -400, 500}, '{0, 0, 0, 0, -5, -7}};
    foreach (pats[i]) send_sample(pats[i], 1'b0);
    drain_results();
    write_reg(AddrAlpha, 32'h1ffff);
    write_reg(AddrKd, 16'hffff);
    write_reg(AddrKp, 16'hffff);
    write_reg(AddrCap, 15'h7fff);
    write_reg(AddrTroll, 25'h1000000);
    write_reg(AddrTpitch, 25'h0ffffff);
    for (int i = 0; i < 6; i++) send_sample(pats[6 + (i % 4)]);
    drain_results();
    write_reg(AddrRate, 0);
    write_reg(AddrPeriod, 0);
    write_reg(AddrAlpha, 0);
    write_reg(AddrCap, 0);
    for (int i = 0; i < 3; i++) send_sample(pats[10 + i]);
    drain_results();
  endtask

  task automatic test_random_configs();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(AddrAlpha, (ph == 0) ? 65536 : $urandom_range(0, 70000));
      write_reg(AddrPeriod, (ph == 1) ? 24'hffffff : $urandom_range(1, 24'hffffff));
      write_reg(AddrRate, (ph == 2) ? 16'hffff : $urandom_range(1, 2000));
      write_reg(AddrKp, $urandom);
      write_reg(AddrKd, $urandom_range(0, 1) ? $urandom : 0);
      write_reg(AddrTroll, $urandom_range(0, 23592960) - 11796480);
      write_reg(AddrTpitch, $urandom_range(0, 23592960) - 11796480);
      write_reg(AddrCap, $urandom_range(0, 32767));
      rand_idle = (ph != 3);
      for (int i = 0; i < 75; i++) send_sample(random_sample());
      drain_results();
    end
    rand_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_sample(random_sample(), 1'b0);
    join
    drain_results();
    for (int i = 0; i < 4; i++) send_sample(random_sample());
    drain_results();
  endtask

  initial begin
    alpha_q = 64880; period_q = 167772; rate_q = 100; kp_q = 256; kd_q = 0;
    troll_q = 0; tpitch_q = 0; cap_q = 12800;
    roll_st = 0; pitch_st = 0; yaw_st = 0; prev_er = 0; prev_ep = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random_configs();
    drain_results();
    $display("Sent %0d IMU samples, checked %0d motor/attitude items", accepted_in,
             accepted_out);
    $display("Covered directed extremes, %0d random register settings and output backpressure",
             8);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/afpd_pkg.sv
rtl/core/attitude_filter_pd_motor_mixer_top.sv
tb/tb_attitude_filter_pd_motor_mixer_top.sv
